// ----- rtl/hbs_pkg.sv -----
package hbs_pkg;

    // Fixed field widths
    localparam int CELL_W = 24;
    localparam int ADDR_W = 16;
    localparam int POS_W  = 40;
    localparam int CFG_W  = 40;
    localparam int IDX_W  = 3;
    localparam int CS_W   = 24;
    localparam int CNT_W  = 9;
    localparam int FRAC_W = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [IDX_W-1:0] REG_CELL_SIZE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_NODATA_VALUE = 3'd5;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_VALID   = 2'd0,
        STATUS_OUTSIDE = 2'd1,
        STATUS_NODATA  = 2'd2
    } status_t;

    // Request info carried alongside the divider
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] cell_index;
        logic [CELL_W-1:0] cell_value;
        logic              outside;
    } item_meta_t;

    // Control handed to the blend pipeline
    typedef struct packed {
        logic valid;
        logic outside;
    } blend_ctrl_t;

endpackage

// ----- rtl/hbs_ram.sv -----
module hbs_ram
    import hbs_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [CELL_W-1:0] rdata_a,
    output logic [CELL_W-1:0] rdata_b
);

    logic [CELL_W-1:0] mem [STORE_DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/hbs_div.sv -----
module hbs_div
    import hbs_pkg::*;
#(
    parameter int INT_W = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  item_meta_t                  in_meta,
    input  logic [INT_W+CS_W-1:0]       num_x,
    input  logic [INT_W+CS_W-1:0]       num_y,
    input  logic [CS_W-1:0]             divisor,
    output logic                        out_valid,
    output item_meta_t                  out_meta,
    output logic [INT_W+FRAC_W-1:0]     quo_x,
    output logic [INT_W+FRAC_W-1:0]     quo_y
);

    // Restoring division, one quotient bit per stage for both axes.
    // The dividend is (d << 16) with d < divisor << INT_W, so the upper
    // part starts below the divisor.
    localparam int QW = INT_W + FRAC_W;
    localparam int NW = INT_W + CS_W;

    logic            v_reg [QW];
    item_meta_t      m_reg [QW];
    logic [CS_W-1:0] d_reg [QW];
    logic [CS_W-1:0] rx_reg [QW];
    logic [CS_W-1:0] ry_reg [QW];
    logic [QW-1:0]   nx_reg [QW];
    logic [QW-1:0]   ny_reg [QW];
    logic [QW-1:0]   qx_reg [QW];
    logic [QW-1:0]   qy_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic            v_in;
        item_meta_t      m_in;
        logic [CS_W-1:0] d_in;
        logic [CS_W-1:0] rx_in;
        logic [CS_W-1:0] ry_in;
        logic [QW-1:0]   nx_in;
        logic [QW-1:0]   ny_in;
        logic [QW-1:0]   qx_in;
        logic [QW-1:0]   qy_in;
        logic [CS_W:0]   shx;
        logic [CS_W:0]   shy;
        logic [CS_W+1:0] difx;
        logic [CS_W+1:0] dify;
        logic            gex;
        logic            gey;

        if (i == 0)
        begin : g_first
            // Upper part of d is the starting remainder; the low part and
            // the fraction zeros are shifted in one bit per stage
            assign v_in  = in_valid;
            assign m_in  = in_meta;
            assign d_in  = divisor;
            assign rx_in = num_x[NW-1:INT_W];
            assign ry_in = num_y[NW-1:INT_W];
            assign nx_in = {num_x[INT_W-1:0], FRAC_W'(0)};
            assign ny_in = {num_y[INT_W-1:0], FRAC_W'(0)};
            assign qx_in = '0;
            assign qy_in = '0;
        end
        else
        begin : g_next
            assign v_in  = v_reg[i-1];
            assign m_in  = m_reg[i-1];
            assign d_in  = d_reg[i-1];
            assign rx_in = rx_reg[i-1];
            assign ry_in = ry_reg[i-1];
            assign nx_in = nx_reg[i-1];
            assign ny_in = ny_reg[i-1];
            assign qx_in = qx_reg[i-1];
            assign qy_in = qy_reg[i-1];
        end

        // Trial subtract
        assign shx  = {rx_in, nx_in[QW-1-i]};
        assign shy  = {ry_in, ny_in[QW-1-i]};
        assign difx = {1'b0, shx} - {2'b00, d_in};
        assign dify = {1'b0, shy} - {2'b00, d_in};
        assign gex  = ~difx[CS_W+1];
        assign gey  = ~dify[CS_W+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[i]  <= m_in;
            d_reg[i]  <= d_in;
            nx_reg[i] <= nx_in;
            ny_reg[i] <= ny_in;
            rx_reg[i] <= gex ? difx[CS_W-1:0] : shx[CS_W-1:0];
            ry_reg[i] <= gey ? dify[CS_W-1:0] : shy[CS_W-1:0];
            qx_reg[i] <= qx_in | (QW'(gex) << (QW - 1 - i));
            qy_reg[i] <= qy_in | (QW'(gey) << (QW - 1 - i));
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_meta  = m_reg[QW-1];
    assign quo_x     = qx_reg[QW-1];
    assign quo_y     = qy_reg[QW-1];

endmodule

// ----- rtl/hbs_blend.sv -----
module hbs_blend
    import hbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  blend_ctrl_t       ctrl,
    input  logic [FRAC_W:0]   tx,
    input  logic [FRAC_W:0]   ty,
    input  logic [CELL_W-1:0] z00,
    input  logic [CELL_W-1:0] z10,
    input  logic [CELL_W-1:0] z01,
    input  logic [CELL_W-1:0] z11,
    input  logic [CELL_W-1:0] nodata,
    output logic              res_valid,
    output logic [1:0]        res_status,
    output logic [CELL_W-1:0] res_elevation
);

    localparam int WT_W = FRAC_W + 1;
    localparam int P1_W = CELL_W + WT_W + 1;
    localparam int P2_W = P1_W + WT_W + 1;
    localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRAC_W;

    // Stage 1: corner weights in x, nodata check
    logic                   v1_reg, v1_next;
    logic [1:0]             st1_reg, st1_next;
    logic signed [P1_W-1:0] p00_reg, p10_reg, p01_reg, p11_reg;
    logic [WT_W-1:0]        ty1_reg;
    logic [WT_W-1:0]        wx0;
    logic                   nd;

    assign wx0 = ONE - tx;
    assign nd  = (z00 == nodata) || (z10 == nodata) || (z01 == nodata) || (z11 == nodata);

    always_comb
    begin
        v1_next = ctrl.valid;
        if (ctrl.outside)
        begin
            st1_next = STATUS_OUTSIDE;
        end
        else if (nd)
        begin
            st1_next = STATUS_NODATA;
        end
        else
        begin
            st1_next = STATUS_VALID;
        end
    end

    // Stage 2: row sums
    logic                   v2_reg;
    logic [1:0]             st2_reg;
    logic signed [P1_W-1:0] a_reg, b_reg;
    logic [WT_W-1:0]        ty2_reg;

    // Stage 3: weights in y
    logic                   v3_reg;
    logic [1:0]             st3_reg;
    logic signed [P2_W-1:0] pa_reg, pb_reg;
    logic [WT_W-1:0]        wy0;
    logic signed [P2_W-1:0] sum;

    assign wy0 = ONE - ty2_reg;
    assign sum = pa_reg + pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            v1_reg    <= v1_next;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            res_valid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg <= st1_next;
        ty1_reg <= ty;
        p00_reg <= P1_W'($signed(z00) * $signed({1'b0, wx0}));
        p10_reg <= P1_W'($signed(z10) * $signed({1'b0, tx}));
        p01_reg <= P1_W'($signed(z01) * $signed({1'b0, wx0}));
        p11_reg <= P1_W'($signed(z11) * $signed({1'b0, tx}));

        st2_reg <= st1_reg;
        ty2_reg <= ty1_reg;
        a_reg   <= p00_reg + p10_reg;
        b_reg   <= p01_reg + p11_reg;

        st3_reg <= st2_reg;
        pa_reg  <= P2_W'(a_reg * $signed({1'b0, wy0}));
        pb_reg  <= P2_W'(b_reg * $signed({1'b0, ty2_reg}));

        // floor to Q.8: drop 32 fraction bits
        res_status    <= st3_reg;
        res_elevation <= (st3_reg == STATUS_VALID) ? sum[2*FRAC_W+CELL_W-1:2*FRAC_W] : '0;
    end

endmodule

// ----- rtl/heightfield_bilinear_sampler.sv -----
// Channel   Signals                                         Accepted at
// request   start busy kind cell_index cell_value x_pos y_pos  edge with start & !busy
// result    result_strobe status elevation                  edge ending the strobe cycle
// config    cfg_write cfg_index cfg_data                    edge with cfg_write high
//
// One request enters every cycle; busy is never raised.
// The time from an accepted query to its result is set mostly by the divider, which
// resolves one quotient bit per stage.
// Writes reach the height store at the same stage queries read it, so order holds.
// rst_n clears the valid bits and sets config to its defaults; the height store keeps no reset state.
// The receiver cannot stall; nothing in the pipeline ever waits.
module heightfield_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [ADDR_W-1:0] cell_index,
    input  logic [CELL_W-1:0] cell_value,
    input  logic [POS_W-1:0]  x_pos,
    input  logic [POS_W-1:0]  y_pos,
    output logic              result_strobe,
    output logic [1:0]        status,
    output logic [CELL_W-1:0] elevation,
    input  logic              cfg_write,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int MAXG = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int CI   = $clog2(MAXG);
    localparam int QW   = CI + FRAC_W;
    localparam int CWC  = $clog2(MAX_COLUMNS + 1);
    localparam int CWR  = $clog2(MAX_ROWS + 1);
    localparam int LX_W = CWC + CS_W;
    localparam int LY_W = CWR + CS_W;

    assign busy = 1'b0;

    // Configuration registers
    logic [CNT_W-1:0]  col_count_reg;
    logic [CNT_W-1:0]  row_count_reg;
    logic [POS_W-1:0]  origin_x_reg;
    logic [POS_W-1:0]  origin_y_reg;
    logic [CS_W-1:0]   cell_size_reg;
    logic [CELL_W-1:0] nodata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= CNT_W'(2);
            row_count_reg <= CNT_W'(2);
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            cell_size_reg <= CS_W'(256);
            nodata_reg    <= CELL_W'(-2559744);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COLUMN_COUNT: col_count_reg <= cfg_data[CNT_W-1:0];
                REG_ROW_COUNT:    row_count_reg <= cfg_data[CNT_W-1:0];
                REG_ORIGIN_X:     origin_x_reg  <= cfg_data[POS_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg  <= cfg_data[POS_W-1:0];
                REG_CELL_SIZE:    cell_size_reg <= cfg_data[CS_W-1:0];
                REG_NODATA_VALUE: nodata_reg    <= cfg_data[CELL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamped grid size, cell size and extent
    logic [CWC-1:0]  cols_reg, cols_next;
    logic [CWR-1:0]  rows_reg, rows_next;
    logic [CS_W-1:0] cs_reg, cs_next;
    logic [LX_W-1:0] limx_reg, limx_next;
    logic [LY_W-1:0] limy_reg, limy_next;

    always_comb
    begin
        if (col_count_reg < CNT_W'(2))
        begin
            cols_next = CWC'(2);
        end
        else if (32'(col_count_reg) > MAX_COLUMNS)
        begin
            cols_next = CWC'(MAX_COLUMNS);
        end
        else
        begin
            cols_next = CWC'(col_count_reg);
        end
        if (row_count_reg < CNT_W'(2))
        begin
            rows_next = CWR'(2);
        end
        else if (32'(row_count_reg) > MAX_ROWS)
        begin
            rows_next = CWR'(MAX_ROWS);
        end
        else
        begin
            rows_next = CWR'(row_count_reg);
        end
        cs_next   = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;
        limx_next = LX_W'(cols_next - CWC'(1)) * LX_W'(cs_next);
        limy_next = LY_W'(rows_next - CWR'(1)) * LY_W'(cs_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CWC'(2);
            rows_reg <= CWR'(2);
            cs_reg   <= CS_W'(256);
            limx_reg <= LX_W'(256);
            limy_reg <= LY_W'(256);
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            cs_reg   <= cs_next;
            limx_reg <= limx_next;
            limy_reg <= limy_next;
        end
    end

    // Stage 0: capture request
    logic              v0_reg;
    logic              kind0_reg;
    logic [ADDR_W-1:0] idx0_reg;
    logic [CELL_W-1:0] val0_reg;
    logic [POS_W-1:0]  x0_reg, y0_reg;

    // Stage 1: offsets from origin
    logic              v1_reg;
    logic              kind1_reg;
    logic [ADDR_W-1:0] idx1_reg;
    logic [CELL_W-1:0] val1_reg;
    logic [POS_W:0]    dx1_reg, dy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start & ~busy;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind0_reg <= kind;
        idx0_reg  <= cell_index;
        val0_reg  <= cell_value;
        x0_reg    <= x_pos;
        y0_reg    <= y_pos;
        kind1_reg <= kind0_reg;
        idx1_reg  <= idx0_reg;
        val1_reg  <= val0_reg;
        dx1_reg   <= {x0_reg[POS_W-1], x0_reg} - {origin_x_reg[POS_W-1], origin_x_reg};
        dy1_reg   <= {y0_reg[POS_W-1], y0_reg} - {origin_y_reg[POS_W-1], origin_y_reg};
    end

    // Range check; outside items feed zero to the divider
    logic                   outside;
    item_meta_t             meta1;
    logic [CI+CS_W-1:0]     num_x, num_y;

    assign outside = dx1_reg[POS_W] | dy1_reg[POS_W]
                   | (dx1_reg[POS_W-1:0] > POS_W'(limx_reg))
                   | (dy1_reg[POS_W-1:0] > POS_W'(limy_reg));
    assign num_x   = outside ? '0 : dx1_reg[CI+CS_W-1:0];
    assign num_y   = outside ? '0 : dy1_reg[CI+CS_W-1:0];

    always_comb
    begin
        meta1.kind       = kind1_reg;
        meta1.cell_index = idx1_reg;
        meta1.cell_value = val1_reg;
        meta1.outside    = outside;
    end

    logic          vd;
    item_meta_t    md;
    logic [QW-1:0] qx, qy;

    hbs_div #(
        .INT_W (CI)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_meta   (meta1),
        .num_x     (num_x),
        .num_y     (num_y),
        .divisor   (cs_reg),
        .out_valid (vd),
        .out_meta  (md),
        .quo_x     (qx),
        .quo_y     (qy)
    );

    // Stage A: clamp cell index, fractions, top-first row
    logic              va_reg;
    item_meta_t        ma_reg;
    logic [CI-1:0]     c0_reg, c0_next;
    logic [CI-1:0]     r0_next;
    logic [CWR-1:0]    rt0_reg, rt0_next;
    logic [FRAC_W:0]   txa_reg, txa_next;
    logic [FRAC_W:0]   tya_reg, tya_next;
    logic [CI-1:0]     ix, iy;
    logic [CWC-1:0]    cmax;
    logic [CWR-1:0]    rmax;

    assign ix   = qx[QW-1:FRAC_W];
    assign iy   = qy[QW-1:FRAC_W];
    assign cmax = cols_reg - CWC'(2);
    assign rmax = rows_reg - CWR'(2);

    always_comb
    begin
        c0_next  = (32'(ix) > 32'(cmax)) ? CI'(cmax) : ix;
        r0_next  = (32'(iy) > 32'(rmax)) ? CI'(rmax) : iy;
        txa_next = {ix != c0_next, qx[FRAC_W-1:0]};
        tya_next = {iy != r0_next, qy[FRAC_W-1:0]};
        rt0_next = rows_reg - CWR'(1) - CWR'(r0_next);
    end

    // Stage B: base address of the upper left corner
    logic              vb_reg;
    item_meta_t        mb_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [FRAC_W:0]   txb_reg, tyb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= vd;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= md;
        c0_reg   <= c0_next;
        rt0_reg  <= rt0_next;
        txa_reg  <= txa_next;
        tya_reg  <= tya_next;
        mb_reg   <= ma_reg;
        txb_reg  <= txa_reg;
        tyb_reg  <= tya_reg;
        addr_reg <= ADDR_W'(32'(rt0_reg) * 32'(cols_reg) + 32'(c0_reg));
    end

    // Stage C: four corner reads, cell writes in order with them
    logic [ADDR_W-1:0] addr10, addr01, addr11;
    logic              we;
    logic [CELL_W-1:0] z00, z10, z01, z11;

    assign addr10 = addr_reg + ADDR_W'(1);
    assign addr01 = addr_reg - ADDR_W'(cols_reg);
    assign addr11 = addr01 + ADDR_W'(1);
    assign we     = vb_reg && (mb_reg.kind == KIND_WRITE);

    hbs_ram u_ram_upper (
        .clk     (clk),
        .we      (we),
        .waddr   (mb_reg.cell_index),
        .wdata   (mb_reg.cell_value),
        .raddr_a (addr_reg),
        .raddr_b (addr10),
        .rdata_a (z00),
        .rdata_b (z10)
    );

    hbs_ram u_ram_lower (
        .clk     (clk),
        .we      (we),
        .waddr   (mb_reg.cell_index),
        .wdata   (mb_reg.cell_value),
        .raddr_a (addr01),
        .raddr_b (addr11),
        .rdata_a (z01),
        .rdata_b (z11)
    );

    // Stage D: query control lined up with read data
    logic            vq_reg;
    logic            outd_reg;
    logic [FRAC_W:0] txd_reg, tyd_reg;
    blend_ctrl_t     bctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
        end
        else
        begin
            vq_reg <= vb_reg && (mb_reg.kind == KIND_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        outd_reg <= mb_reg.outside;
        txd_reg  <= txb_reg;
        tyd_reg  <= tyb_reg;
    end

    always_comb
    begin
        bctrl.valid   = vq_reg;
        bctrl.outside = outd_reg;
    end

    hbs_blend u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (bctrl),
        .tx            (txd_reg),
        .ty            (tyd_reg),
        .z00           (z00),
        .z10           (z10),
        .z01           (z01),
        .z11           (z11),
        .nodata        (nodata_reg),
        .res_valid     (result_strobe),
        .res_status    (status),
        .res_elevation (elevation)
    );

endmodule

// ----- rtl/hbs_checker.sv -----
module hbs_checker
    import hbs_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              kind,
    input logic              result_strobe,
    input logic [1:0]        status,
    input logic [CELL_W-1:0] elevation
);

    localparam int MAXG = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int LAT  = $clog2(MAXG) + FRAC_W + 9;

    // Fully pipelined: never holds requests off
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every query yields a result after the fixed latency
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_QUERY) |-> ##LAT result_strobe)
        else $error("query result missing");

    // No result without a query accepted that long ago
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && !busy && kind == KIND_QUERY, LAT))
        else $error("result without query");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (status == STATUS_VALID || status == STATUS_OUTSIDE
                           || status == STATUS_NODATA))
        else $error("bad status code");

    a_zero_elev: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && status != STATUS_VALID) |-> elevation == '0)
        else $error("elevation nonzero on failed query");

endmodule

bind heightfield_bilinear_sampler hbs_checker #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
) u_hbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .result_strobe (result_strobe),
    .status        (status),
    .elevation     (elevation)
);
